// ----- sv/lss_pkg.sv -----
package lss_pkg;

  localparam int unsigned ITEM_BITS  = 32;
  localparam int unsigned COUNT_BITS = 9;
  localparam int unsigned POS_BITS   = 8;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_MPOP = 3'd2;
  localparam logic [2:0] OP_PEEK = 3'd3;
  localparam logic [2:0] OP_FIND = 3'd4;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_FULL  = 2'd1;
  localparam logic [1:0] FAULT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [ITEM_BITS-1:0]  item_in;
    logic [COUNT_BITS-1:0] count;
  } in_word_t;

  typedef struct packed {
    logic [ITEM_BITS-1:0]  item_out;
    logic                  item_valid;
    logic                  found;
    logic [POS_BITS-1:0]   position;
    logic [COUNT_BITS-1:0] fill_count;
    logic [1:0]            fault_code;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_SCAN
  } state_t;

  // what an accepted word needs: result at once, one memory read, or a scan
  typedef enum logic [1:0] {
    KIND_IMM,
    KIND_READ,
    KIND_FIND
  } kind_t;

  typedef struct packed {
    logic accept;
    logic emit_imm;
    logic emit_rd;
    logic emit_hit;
    logic emit_miss;
    logic scan_next;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  out_free;
    logic  hit;
    logic  last;
  } status_t;

endpackage

// ----- sv/lifo_stack_with_search.sv -----
// Push, faults, zero-count multi-pop, out-of-range peek, find on empty: result registered
// in the cycle after accept, one word per cycle while the output is not stalled. Pop,
// multi-pop, peek: result through the RAM read register, then the result register; no new
// word is taken until it is emitted (registered read through the single RAM read port).
// Find reads one entry per cycle while the result slot is free; input stalls for the whole scan.
// Reset (rst_n, synchronous): fill count, controller, result valid cleared; storage kept.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lss_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lss_pkg::out_word_t out_data
);

  lss_pkg::cmd_t    cmd;
  lss_pkg::status_t st;

  lss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lss_dp #(
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sv/lss_ram.sv -----
module lss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lss_ctrl.sv -----
module lss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lss_pkg::status_t st,
  output lss_pkg::cmd_t    cmd
);

  lss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lss_pkg::ST_IDLE: begin
        // input held off while in reset
        in_stall = !st.out_free || !rst_n;
        if (in_valid && st.out_free && rst_n) begin
          cmd.accept = 1'b1;
          case (st.kind)
            lss_pkg::KIND_IMM:  cmd.emit_imm = 1'b1;
            lss_pkg::KIND_READ: state_nxt = lss_pkg::ST_RDWAIT;
            lss_pkg::KIND_FIND: state_nxt = lss_pkg::ST_SCAN;
            default:            cmd.emit_imm = 1'b1;
          endcase
        end
      end
      lss_pkg::ST_RDWAIT: begin
        // read data holds in the RAM register until the result slot frees
        if (st.out_free) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = lss_pkg::ST_IDLE;
        end
      end
      lss_pkg::ST_SCAN: begin
        if (st.out_free) begin
          if (st.hit) begin
            cmd.emit_hit = 1'b1;
            state_nxt    = lss_pkg::ST_IDLE;
          end else if (st.last) begin
            cmd.emit_miss = 1'b1;
            state_nxt     = lss_pkg::ST_IDLE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = lss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/lss_dp.sv -----
module lss_dp #(
  parameter int unsigned DEPTH      = 256,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lss_pkg::in_word_t  in_data,
  input  lss_pkg::cmd_t      cmd,
  output lss_pkg::status_t   st,
  output logic               out_valid,
  input  logic               out_stall,
  output lss_pkg::out_word_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (OW > lss_pkg::COUNT_BITS) ? OW : lss_pkg::COUNT_BITS;

  logic [OW-1:0]         occ_r, occ_nxt;
  logic [ITEM_WIDTH-1:0] key_r;
  logic [AW-1:0]         sa_r;
  logic [AW-1:0]         idx_r;
  lss_pkg::out_word_t    out_r, out_nxt;
  logic                  out_valid_r;

  logic [CW-1:0]         occ_ext, n_ext;
  logic                  full, empty, n_zero, n_over, peek_ok;
  logic [OW-1:0]         mpop_occ;
  logic [AW-1:0]         acc_addr;
  logic [1:0]            imm_fault;
  lss_pkg::kind_t        kind;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         rd_addr;
  logic [ITEM_WIDTH-1:0] rd_data;
  logic                  emit;

  assign occ_ext  = CW'(occ_r);
  assign n_ext    = CW'(in_data.count);
  assign full     = (occ_r == OW'(DEPTH));
  assign empty    = (occ_r == '0);
  assign n_zero   = (in_data.count == '0);
  assign n_over   = (n_ext >= occ_ext);
  assign peek_ok  = !n_over;
  assign mpop_occ = n_over ? '0 : OW'(occ_ext - n_ext);

  always_comb begin
    kind      = lss_pkg::KIND_IMM;
    occ_nxt   = occ_r;
    acc_addr  = AW'(occ_r - 1'b1);
    imm_fault = lss_pkg::FAULT_NONE;
    case (in_data.opcode)
      lss_pkg::OP_PUSH: begin
        if (full) begin
          imm_fault = lss_pkg::FAULT_FULL;
        end else begin
          occ_nxt = occ_r + 1'b1;
        end
      end
      lss_pkg::OP_POP: begin
        if (empty) begin
          imm_fault = lss_pkg::FAULT_EMPTY;
        end else begin
          kind    = lss_pkg::KIND_READ;
          occ_nxt = occ_r - 1'b1;
        end
      end
      lss_pkg::OP_MPOP: begin
        if (n_zero) begin
          imm_fault = lss_pkg::FAULT_NONE;
        end else if (empty) begin
          imm_fault = lss_pkg::FAULT_EMPTY;
        end else begin
          // deepest removed entry sits at the new fill level
          kind     = lss_pkg::KIND_READ;
          occ_nxt  = mpop_occ;
          acc_addr = AW'(mpop_occ);
        end
      end
      lss_pkg::OP_PEEK: begin
        if (peek_ok) begin
          kind     = lss_pkg::KIND_READ;
          acc_addr = AW'(occ_ext - 1'b1 - n_ext);
        end
      end
      lss_pkg::OP_FIND: begin
        if (!empty) begin
          kind = lss_pkg::KIND_FIND;
        end
      end
      default: begin
        kind = lss_pkg::KIND_IMM;
      end
    endcase
  end

  assign wr_en   = cmd.accept && (in_data.opcode == lss_pkg::OP_PUSH) && !full;
  assign rd_en   = (cmd.accept && (kind != lss_pkg::KIND_IMM)) || cmd.scan_next;
  assign rd_addr = cmd.scan_next ? (sa_r - 1'b1) : acc_addr;

  lss_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(occ_r)),
    .wr_data (ITEM_WIDTH'(in_data.item_in)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.accept) begin
      occ_r <= occ_nxt;
    end
  end

  // scan pointer: sa_r is the address whose data is on rd_data
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= ITEM_WIDTH'(in_data.item_in);
      sa_r  <= acc_addr;
      idx_r <= '0;
    end else if (cmd.scan_next) begin
      sa_r  <= sa_r - 1'b1;
      idx_r <= idx_r + 1'b1;
    end
  end

  assign st.kind     = kind;
  assign st.out_free = !out_valid_r || !out_stall;
  assign st.hit      = (rd_data == key_r);
  assign st.last     = (sa_r == '0);

  assign emit = cmd.emit_imm || cmd.emit_rd || cmd.emit_hit || cmd.emit_miss;

  always_comb begin
    out_nxt            = '0;
    out_nxt.fill_count = lss_pkg::COUNT_BITS'(occ_r);
    if (cmd.emit_imm) begin
      out_nxt.fill_count = lss_pkg::COUNT_BITS'(occ_nxt);
      out_nxt.fault_code = imm_fault;
    end else if (cmd.emit_rd) begin
      out_nxt.item_out   = lss_pkg::ITEM_BITS'(rd_data);
      out_nxt.item_valid = 1'b1;
    end else if (cmd.emit_hit) begin
      out_nxt.found    = 1'b1;
      out_nxt.position = lss_pkg::POS_BITS'(idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(DEPTH))
    else $error("fill count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || !out_stall))
    else $error("result written over a pending word");

  a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_next |-> (sa_r != '0))
    else $error("scan stepped below the bottom entry");

  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.item_valid && out_r.found))
    else $error("item and match flagged together");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("push did not grow the stack");
`endif

endmodule

// ----- sim/tb_lifo_stack_with_search.sv -----
module tb_lifo_stack_with_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned LIMIT_CYCLES = 2000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  typedef enum int {
    GROW,
    SHRINK,
    MIX
  } fill_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lss_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lss_pkg::out_word_t out_data;

  // predictor state
  logic [lss_pkg::ITEM_BITS-1:0] stack_mem [STACK_DEPTH];
  int unsigned stack_fill = 0;
  lss_pkg::out_word_t result_q [$];

  lss_pkg::in_word_t word_q [$];
  int unsigned plan_fill = 0;
  bit in_taken = 1'b0;
  bit quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned rcv_gap = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned bad_cnt = 0;
  int unsigned cyc = 0;

  lifo_stack_with_search #(
    .DEPTH     (STACK_DEPTH),
    .ITEM_WIDTH(lss_pkg::ITEM_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic lss_pkg::out_word_t stack_apply(lss_pkg::in_word_t w);
    lss_pkg::out_word_t r;
    int unsigned n;
    int unsigned i;
    bit hit;
    r = '0;
    n = 32'(w.count);
    hit = 1'b0;
    case (w.opcode)
      lss_pkg::OP_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          r.fault_code = lss_pkg::FAULT_FULL;
        end else begin
          stack_mem[stack_fill] = w.item_in;
          stack_fill++;
        end
      end
      lss_pkg::OP_POP: begin
        if (stack_fill == 0) begin
          r.fault_code = lss_pkg::FAULT_EMPTY;
        end else begin
          stack_fill--;
          r.item_out = stack_mem[stack_fill];
          r.item_valid = 1'b1;
        end
      end
      lss_pkg::OP_MPOP: begin
        if (n != 0) begin
          if (stack_fill == 0) begin
            r.fault_code = lss_pkg::FAULT_EMPTY;
          end else begin
            stack_fill = (n >= stack_fill) ? 0 : stack_fill - n;
            r.item_out = stack_mem[stack_fill];
            r.item_valid = 1'b1;
          end
        end
      end
      lss_pkg::OP_PEEK: begin
        if (n < stack_fill) begin
          r.item_out = stack_mem[stack_fill - 1 - n];
          r.item_valid = 1'b1;
        end
      end
      lss_pkg::OP_FIND: begin
        // first match counting down from the top
        for (i = 0; i < stack_fill; i++) begin
          if (!hit && stack_mem[stack_fill - 1 - i] == w.item_in) begin
            hit = 1'b1;
            r.found = 1'b1;
            r.position = lss_pkg::POS_BITS'(i);
          end
        end
      end
      default: ;
    endcase
    r.fill_count = lss_pkg::COUNT_BITS'(stack_fill);
    return r;
  endfunction

  task automatic check_result(lss_pkg::out_word_t got);
    lss_pkg::out_word_t want;
    bit ok;
    if (result_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("cycle %0d: result word with none pending: %h", cyc, got);
    end else begin
      want = result_q.pop_front();
      ok = (got.item_out === want.item_out) && (got.item_valid === want.item_valid) &&
           (got.found === want.found) && (got.position === want.position) &&
           (got.fill_count === want.fill_count) && (got.fault_code === want.fault_code);
      if (!ok) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $display("cycle %0d: exp item=%h v=%b found=%b pos=%0d fill=%0d fault=%0d",
                   cyc, want.item_out, want.item_valid, want.found, want.position,
                   want.fill_count, want.fault_code);
          $display("cycle %0d: got item=%h v=%b found=%b pos=%0d fill=%0d fault=%0d",
                   cyc, got.item_out, got.item_valid, got.found, got.position,
                   got.fill_count, got.fault_code);
        end
      end
    end
  endtask

  task automatic queue_word(logic [2:0] op, logic [lss_pkg::ITEM_BITS-1:0] item,
                            logic [lss_pkg::COUNT_BITS-1:0] cnt);
    lss_pkg::in_word_t w;
    w.opcode = op;
    w.item_in = item;
    w.count = cnt;
    word_q.push_back(w);
    // track fill only, to steer the random mix
    case (op)
      lss_pkg::OP_PUSH: if (plan_fill < STACK_DEPTH) plan_fill++;
      lss_pkg::OP_POP: if (plan_fill > 0) plan_fill--;
      lss_pkg::OP_MPOP: if (cnt != 0) plan_fill = (cnt >= plan_fill) ? 0 : plan_fill - cnt;
      default: ;
    endcase
  endtask

  task automatic queue_random(fill_mode_t mode);
    int unsigned r;
    int unsigned pw;
    int unsigned pp;
    int unsigned pm;
    logic [lss_pkg::ITEM_BITS-1:0] item;
    logic [lss_pkg::COUNT_BITS-1:0] cnt;
    logic [2:0] op;
    // small value pool so finds hit often
    item = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15);
    cnt = lss_pkg::COUNT_BITS'($urandom_range(0, 511));
    case (mode)
      GROW: begin
        pw = 55; pp = 10; pm = 5;
      end
      SHRINK: begin
        pw = 20; pp = 30; pm = 20;
      end
      default: begin
        pw = 35; pp = 20; pm = 10;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < pw) begin
      queue_word(lss_pkg::OP_PUSH, item, cnt);
    end else if (r < pw + pp) begin
      queue_word(lss_pkg::OP_POP, item, cnt);
    end else if (r < pw + pp + pm) begin
      if ($urandom_range(0, 9) != 0) cnt = lss_pkg::COUNT_BITS'($urandom_range(1, 4));
      queue_word(lss_pkg::OP_MPOP, item, cnt);
    end else if (r >= 97) begin
      op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      queue_word(op, item, cnt);
    end else if (r % 2 == 0) begin
      if ($urandom_range(0, 6) != 0)
        cnt = lss_pkg::COUNT_BITS'($urandom_range(0, plan_fill));
      queue_word(lss_pkg::OP_PEEK, item, cnt);
    end else begin
      queue_word(lss_pkg::OP_FIND, item, cnt);
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (word_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  always @(negedge clk) begin : drive_in
    lss_pkg::in_word_t nxt_data;
    logic nxt_valid;
    nxt_data = in_data;
    nxt_valid = in_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (!in_valid || in_taken) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (word_q.size() > 0) begin
        nxt_data = word_q.pop_front();
        nxt_valid = 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 12);
      end
    end
    in_taken = 1'b0;
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  always @(negedge clk) begin : drive_stall
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet && $urandom_range(0, 7) == 0) rcv_gap = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin : take_in
    if (rst_n && in_valid && !in_stall) begin
      result_q.push_back(stack_apply(in_data));
      in_taken = 1'b1;
    end
  end

  always @(posedge clk) begin : take_out
    if (rst_n && out_valid && !out_stall) check_result(out_data);
  end

  always @(posedge clk) begin : watchdog
    cyc++;
    if (cyc > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    fill_mode_t mode;
    int unsigned c;
    int unsigned k;
    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // empty stack corners
    queue_word(lss_pkg::OP_FIND, 32'h0000_0000, 9'd0);
    queue_word(lss_pkg::OP_POP, 32'hFFFF_FFFF, 9'h1FF);
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd5);
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd0);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd0);
    // small stack: peeks, hits and misses
    queue_word(lss_pkg::OP_PUSH, 32'h0000_0000, 9'h1FF);
    queue_word(lss_pkg::OP_PUSH, 32'hFFFF_FFFF, 9'd0);
    queue_word(lss_pkg::OP_PUSH, 32'h1234_5678, 9'd0);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd0);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd2);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd3);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'h1FF);
    queue_word(lss_pkg::OP_FIND, 32'hFFFF_FFFF, 9'd0);
    queue_word(lss_pkg::OP_FIND, 32'h0000_0000, 9'd0);
    queue_word(lss_pkg::OP_FIND, 32'hDEAD_BEEF, 9'd0);
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd0);
    queue_word(lss_pkg::OP_POP, 32'h0, 9'd0);
    queue_word(OP_SPARE_FIRST, 32'hFFFF_FFFF, 9'h1FF);
    queue_word(OP_SPARE_MID, 32'hFFFF_FFFF, 9'h1FF);
    queue_word(OP_SPARE_LAST, 32'hFFFF_FFFF, 9'h1FF);
    queue_word(lss_pkg::OP_PUSH, 32'h5555_AAAA, 9'd0);
    // count past the fill empties the stack and returns the bottom word
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd256);
    queue_word(lss_pkg::OP_PUSH, 32'hAAAA_5555, 9'd0);
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd1);
    wait_drained();

    // fill to the top with the receiver held off, then overflow
    hold_req++;
    queue_word(lss_pkg::OP_PUSH, 32'hC0DE_0001, 9'd0);
    while (plan_fill < STACK_DEPTH)
      queue_word(lss_pkg::OP_PUSH,
                 ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15),
                 lss_pkg::COUNT_BITS'($urandom_range(0, 511)));
    repeat (3)
      queue_word(lss_pkg::OP_PUSH, $urandom, lss_pkg::COUNT_BITS'($urandom_range(0, 511)));
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd255);
    queue_word(lss_pkg::OP_PEEK, 32'h0, 9'd256);
    queue_word(lss_pkg::OP_FIND, 32'hC0DE_0001, 9'd0);
    queue_word(lss_pkg::OP_FIND, 32'hDEAD_0000, 9'd0);
    queue_word(lss_pkg::OP_POP, 32'h0, 9'd0);
    queue_word(lss_pkg::OP_PUSH, 32'h0F0F_F0F0, 9'd0);
    queue_word(lss_pkg::OP_MPOP, 32'h0, 9'd300);

    for (c = 0; c < 23; c++) begin
      while (word_q.size() > 8) @(posedge clk);
      if (c == 20 || $urandom_range(0, 5) == 0) wait_drained();
      quiet = (c >= 20) || (c == 9) || (c == 10);
      if (plan_fill > 200) mode = SHRINK;
      else if (plan_fill < 10 || c < 3) mode = GROW;
      else mode = fill_mode_t'($urandom_range(0, 2));
      for (k = 0; k < 50; k++) queue_random(mode);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_cnt == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
